@@ hdl/bmhpq_pkg.sv @@
// ----------------------------------------------------------------------------
// bmhpq_pkg
// Shared types, codes and default sizes for the binary min-heap priority
// queue unit.
// ----------------------------------------------------------------------------
package bmhpq_pkg;

    // Default sizes of the heap store
    localparam int unsigned CAPACITY_DEF = 1024;
    localparam int unsigned KEY_BITS_DEF = 32;
    localparam int unsigned TAG_BITS_DEF = 16;

    // Fixed widths of the request and result ports
    localparam int unsigned CMD_W      = 2;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned PORT_KEY_W = 32;
    localparam int unsigned PORT_TAG_W = 16;
    localparam int unsigned OCC_W      = 11;

    // Request commands
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_PEEK   = 2'd2
    } cmd_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

endpackage

@@ hdl/binary_min_heap_priority_queue_unit.sv @@
// Insert, full, empty and unused commands load the pending-result register when
// the request is taken; remove and peek load it in S_ROOT, once the root is read.
// A sift walks one heap level per cycle through the entry store; no new request
// is taken while a sift runs or a result waits in the pending-result register.
// Reset clears the entry count, sequencer state and handshake state only; the entry
// store is not cleared, and no clearing pass runs.
// ----------------------------------------------------------------------------
// binary_min_heap_priority_queue_unit
// Min-heap priority queue of key and tag pairs held in a dual-read store,
// with insert, remove-minimum and peek-minimum requests.
// ----------------------------------------------------------------------------
module binary_min_heap_priority_queue_unit #(
    parameter int unsigned CAPACITY = bmhpq_pkg::CAPACITY_DEF,
    parameter int unsigned KEY_BITS = bmhpq_pkg::KEY_BITS_DEF,
    parameter int unsigned TAG_BITS = bmhpq_pkg::TAG_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [bmhpq_pkg::CMD_W-1:0]           s_command,
    input  logic signed [bmhpq_pkg::PORT_KEY_W-1:0] s_key,
    input  logic [bmhpq_pkg::PORT_TAG_W-1:0]      s_tag,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [bmhpq_pkg::STATUS_W-1:0]        m_status,
    output logic signed [bmhpq_pkg::PORT_KEY_W-1:0] m_out_key,
    output logic [bmhpq_pkg::PORT_TAG_W-1:0]      m_out_tag,
    output logic [bmhpq_pkg::OCC_W-1:0]           m_occupancy
);

    import bmhpq_pkg::*;

    localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
    localparam int unsigned ADDR_W = $clog2(CAPACITY);
    localparam int unsigned DATA_W = KEY_BITS + TAG_BITS;

    logic [63:0]          key_in_ext;
    logic [31:0]          tag_in_ext;
    logic [KEY_BITS-1:0]  key_in_st;
    logic [TAG_BITS-1:0]  tag_in_st;
    logic [KEY_BITS-1:0]  key_out_st;
    logic [TAG_BITS-1:0]  tag_out_st;
    logic [63:0]          key_out_ext;
    logic [31:0]          tag_out_ext;
    logic [31:0]          count_ext;
    logic [CNT_W-1:0]     count_out;
    status_t              status_out;

    logic                 mem_wr_en;
    logic [ADDR_W-1:0]    mem_wr_addr;
    logic [DATA_W-1:0]    mem_wr_data;
    logic [ADDR_W-1:0]    mem_rd_addr_a;
    logic [ADDR_W-1:0]    mem_rd_addr_b;
    logic [DATA_W-1:0]    mem_rd_data_a;
    logic [DATA_W-1:0]    mem_rd_data_b;

    // Sign-extend or truncate the request key to the stored width
    assign key_in_ext = {{(64 - PORT_KEY_W){s_key[PORT_KEY_W-1]}}, s_key};
    assign key_in_st  = key_in_ext[KEY_BITS-1:0];
    assign tag_in_ext = 32'(s_tag);
    assign tag_in_st  = tag_in_ext[TAG_BITS-1:0];

    // Zero-extend or truncate stored fields to the result port widths
    assign key_out_ext = 64'(key_out_st);
    assign tag_out_ext = 32'(tag_out_st);
    assign count_ext   = 32'(count_out);
    assign m_out_key   = key_out_ext[PORT_KEY_W-1:0];
    assign m_out_tag   = tag_out_ext[PORT_TAG_W-1:0];
    assign m_occupancy = count_ext[OCC_W-1:0];
    assign m_status    = status_out;

    bmhpq_ctrl #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS),
        .TAG_BITS (TAG_BITS),
        .CNT_W    (CNT_W),
        .ADDR_W   (ADDR_W)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (cmd_t'(s_command)),
        .s_key_st      (key_in_st),
        .s_tag_st      (tag_in_st),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (status_out),
        .m_key_st      (key_out_st),
        .m_tag_st      (tag_out_st),
        .m_count       (count_out),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data),
        .mem_rd_addr_a (mem_rd_addr_a),
        .mem_rd_addr_b (mem_rd_addr_b),
        .mem_rd_data_a (mem_rd_data_a),
        .mem_rd_data_b (mem_rd_data_b)
    );

    bmhpq_mem #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_mem (
        .aclk      (aclk),
        .wr_en     (mem_wr_en),
        .wr_addr   (mem_wr_addr),
        .wr_data   (mem_wr_data),
        .rd_addr_a (mem_rd_addr_a),
        .rd_addr_b (mem_rd_addr_b),
        .rd_data_a (mem_rd_data_a),
        .rd_data_b (mem_rd_data_b)
    );

endmodule

@@ hdl/bmhpq_mem.sv @@
// ----------------------------------------------------------------------------
// bmhpq_mem
// Heap entry store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module bmhpq_mem #(
    parameter int unsigned DEPTH  = 1024,
    parameter int unsigned ADDR_W = 10,
    parameter int unsigned DATA_W = 48
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [DATA_W-1:0] rd_data_a,
    output logic [DATA_W-1:0] rd_data_b
);

    logic [DATA_W-1:0] ram [DEPTH];
    logic [DATA_W-1:0] rd_data_a_reg;
    logic [DATA_W-1:0] rd_data_b_reg;

    // Write one entry, read two entries a cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram[wr_addr] <= wr_data;
        end
        rd_data_a_reg <= ram[rd_addr_a];
        rd_data_b_reg <= ram[rd_addr_b];
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

@@ hdl/bmhpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// bmhpq_ctrl
// Heap sequencer: decodes a request, walks the heap one level a cycle
// through the entry store, and hands results to a registered output stage.
// ----------------------------------------------------------------------------
module bmhpq_ctrl #(
    parameter int unsigned CAPACITY = 1024,
    parameter int unsigned KEY_BITS = 32,
    parameter int unsigned TAG_BITS = 16,
    parameter int unsigned CNT_W    = 11,
    parameter int unsigned ADDR_W   = 10
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // request side
    input  logic                    s_valid,
    output logic                    s_ready,
    input  bmhpq_pkg::cmd_t         s_cmd,
    input  logic [KEY_BITS-1:0]     s_key_st,
    input  logic [TAG_BITS-1:0]     s_tag_st,
    // result side
    output logic                    m_valid,
    input  logic                    m_ready,
    output bmhpq_pkg::status_t      m_status,
    output logic [KEY_BITS-1:0]     m_key_st,
    output logic [TAG_BITS-1:0]     m_tag_st,
    output logic [CNT_W-1:0]        m_count,
    // entry store
    output logic                    mem_wr_en,
    output logic [ADDR_W-1:0]       mem_wr_addr,
    output logic [KEY_BITS+TAG_BITS-1:0] mem_wr_data,
    output logic [ADDR_W-1:0]       mem_rd_addr_a,
    output logic [ADDR_W-1:0]       mem_rd_addr_b,
    input  logic [KEY_BITS+TAG_BITS-1:0] mem_rd_data_a,
    input  logic [KEY_BITS+TAG_BITS-1:0] mem_rd_data_b
);

    import bmhpq_pkg::*;

    localparam int unsigned DATA_W = KEY_BITS + TAG_BITS;
    localparam logic [CNT_W-1:0]  ONE_IDX = CNT_W'(1);
    localparam logic [CNT_W-1:0]  CAP_IDX = CNT_W'(CAPACITY);
    localparam logic [CNT_W:0]    ONE_WIDE = (CNT_W + 1)'(1);
    localparam logic [ADDR_W-1:0] ROOT_ADDR = '0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_ROOT,
        S_DOWN,
        S_FIN
    } state_t;

    state_t             state_reg,    state_next;
    logic [CNT_W-1:0]   count_reg,    count_next;
    logic [CNT_W-1:0]   cur_reg,      cur_next;
    logic [KEY_BITS-1:0] mov_key_reg, mov_key_next;
    logic [TAG_BITS-1:0] mov_tag_reg, mov_tag_next;
    logic               peek_reg,     peek_next;
    // pending result
    logic               res_pend_reg, res_pend_next;
    status_t            res_status_reg, res_status_next;
    logic [KEY_BITS-1:0] res_key_reg, res_key_next;
    logic [TAG_BITS-1:0] res_tag_reg, res_tag_next;
    logic [CNT_W-1:0]   res_count_reg, res_count_next;
    // output stage
    logic               m_valid_reg,  m_valid_next;
    status_t            m_status_reg, m_status_next;
    logic [KEY_BITS-1:0] m_key_reg,   m_key_next;
    logic [TAG_BITS-1:0] m_tag_reg,   m_tag_next;
    logic [CNT_W-1:0]   m_count_reg,  m_count_next;

    logic [KEY_BITS-1:0] rd_key_a, rd_key_b;
    logic [TAG_BITS-1:0] rd_tag_a, rd_tag_b;
    logic [DATA_W-1:0]   mov_word;
    logic [CNT_W:0]      left_idx, right_idx, grand_idx, grand_m1;
    logic [CNT_W-1:0]    pick_idx, par_idx, ins_idx, rem_count;
    logic                take_right, grand_ok;
    logic [DATA_W-1:0]   pick_word;
    logic [KEY_BITS-1:0] pick_key;
    logic                req_fire;

    function automatic logic key_less(input logic [KEY_BITS-1:0] a,
                                      input logic [KEY_BITS-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

    // One-based heap index to store address
    function automatic logic [ADDR_W-1:0] addr_of(input logic [CNT_W-1:0] idx);
        logic [CNT_W-1:0] d;
        d = idx - ONE_IDX;
        return d[ADDR_W-1:0];
    endfunction

    // Split store words
    assign rd_key_a = mem_rd_data_a[DATA_W-1:TAG_BITS];
    assign rd_tag_a = mem_rd_data_a[TAG_BITS-1:0];
    assign rd_key_b = mem_rd_data_b[DATA_W-1:TAG_BITS];
    assign rd_tag_b = mem_rd_data_b[TAG_BITS-1:0];
    assign mov_word = {mov_key_reg, mov_tag_reg};

    // Child selection for the downward walk
    assign left_idx   = {cur_reg, 1'b0};
    assign right_idx  = left_idx + ONE_WIDE;
    assign take_right = (right_idx <= {1'b0, count_reg}) && key_less(rd_key_b, rd_key_a);
    assign pick_idx   = take_right ? right_idx[CNT_W-1:0] : left_idx[CNT_W-1:0];
    assign pick_word  = take_right ? mem_rd_data_b : mem_rd_data_a;
    assign pick_key   = take_right ? rd_key_b : rd_key_a;
    assign grand_idx  = {pick_idx, 1'b0};
    assign grand_m1   = grand_idx - ONE_WIDE;
    assign grand_ok   = grand_idx <= {1'b0, count_reg};

    assign par_idx   = cur_reg >> 1;
    assign ins_idx   = count_reg + ONE_IDX;
    assign rem_count = count_reg - ONE_IDX;

    assign s_ready  = (state_reg == S_IDLE) && !res_pend_reg;
    assign req_fire = s_valid && s_ready;

    // Next-state, store access and result logic
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        mov_key_next    = mov_key_reg;
        mov_tag_next    = mov_tag_reg;
        peek_next       = peek_reg;
        res_pend_next   = res_pend_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_tag_next    = res_tag_reg;
        res_count_next  = res_count_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_key_next      = m_key_reg;
        m_tag_next      = m_tag_reg;
        m_count_next    = m_count_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = ROOT_ADDR;
        mem_wr_data     = mov_word;
        mem_rd_addr_a   = ROOT_ADDR;
        mem_rd_addr_b   = ROOT_ADDR;

        // Drain the output stage, then move a pending result into it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_pend_reg && (!m_valid_reg || m_ready)) begin
            m_valid_next  = 1'b1;
            m_status_next = res_status_reg;
            m_key_next    = res_key_reg;
            m_tag_next    = res_tag_reg;
            m_count_next  = res_count_reg;
            res_pend_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (req_fire) begin
                    res_pend_next   = 1'b1;
                    res_status_next = STATUS_OK;
                    res_key_next    = '0;
                    res_tag_next    = '0;
                    res_count_next  = count_reg;
                    case (s_cmd)
                        CMD_INSERT: begin
                            if (count_reg == CAP_IDX) begin
                                res_status_next = STATUS_FULL;
                            end else begin
                                count_next     = ins_idx;
                                res_count_next = ins_idx;
                                cur_next       = ins_idx;
                                mov_key_next   = s_key_st;
                                mov_tag_next   = s_tag_st;
                                if (ins_idx == ONE_IDX) begin
                                    // first entry goes straight to the root
                                    mem_wr_en   = 1'b1;
                                    mem_wr_addr = ROOT_ADDR;
                                    mem_wr_data = {s_key_st, s_tag_st};
                                end else begin
                                    mem_rd_addr_a = addr_of(ins_idx >> 1);
                                    state_next    = S_UP;
                                end
                            end
                        end
                        CMD_REMOVE, CMD_PEEK: begin
                            if (count_reg == '0) begin
                                res_status_next = STATUS_EMPTY;
                            end else begin
                                // fetch root and last entry, result follows
                                res_pend_next = 1'b0;
                                peek_next     = (s_cmd == CMD_PEEK);
                                mem_rd_addr_a = ROOT_ADDR;
                                mem_rd_addr_b = addr_of(count_reg);
                                state_next    = S_ROOT;
                            end
                        end
                        default: begin
                            res_status_next = STATUS_OK;
                        end
                    endcase
                end
            end

            S_UP: begin
                if (key_less(rd_key_a, mov_key_reg)) begin
                    // parent strictly smaller: drop the entry here
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = addr_of(cur_reg);
                    mem_wr_data = mov_word;
                    state_next  = S_IDLE;
                end else begin
                    // move the parent down and climb
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = addr_of(cur_reg);
                    mem_wr_data = mem_rd_data_a;
                    cur_next    = par_idx;
                    if (par_idx == ONE_IDX) begin
                        state_next = S_FIN;
                    end else begin
                        mem_rd_addr_a = addr_of(par_idx >> 1);
                    end
                end
            end

            S_ROOT: begin
                res_pend_next   = 1'b1;
                res_status_next = STATUS_OK;
                res_key_next    = rd_key_a;
                res_tag_next    = rd_tag_a;
                if (peek_reg) begin
                    res_count_next = count_reg;
                    state_next     = S_IDLE;
                end else begin
                    res_count_next = rem_count;
                    count_next     = rem_count;
                    mov_key_next   = rd_key_b;
                    mov_tag_next   = rd_tag_b;
                    cur_next       = ONE_IDX;
                    if ({1'b0, rem_count} >= (CNT_W + 1)'(2)) begin
                        mem_rd_addr_a = ADDR_W'(1);
                        mem_rd_addr_b = ADDR_W'(2);
                        state_next    = S_DOWN;
                    end else begin
                        // at most one entry left: any remaining last entry becomes the root
                        if (rem_count != '0) begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = ROOT_ADDR;
                            mem_wr_data = mem_rd_data_b;
                        end
                        state_next = S_IDLE;
                    end
                end
            end

            S_DOWN: begin
                if (key_less(mov_key_reg, pick_key)) begin
                    // entry strictly smaller than the child: stop here
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = addr_of(cur_reg);
                    mem_wr_data = mov_word;
                    state_next  = S_IDLE;
                end else begin
                    // move the child up and descend
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = addr_of(cur_reg);
                    mem_wr_data = pick_word;
                    cur_next    = pick_idx;
                    if (grand_ok) begin
                        mem_rd_addr_a = grand_m1[ADDR_W-1:0];
                        mem_rd_addr_b = grand_idx[ADDR_W-1:0];
                    end else begin
                        state_next = S_FIN;
                    end
                end
            end

            S_FIN: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = addr_of(cur_reg);
                mem_wr_data = mov_word;
                state_next  = S_IDLE;
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            res_pend_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            res_pend_reg <= res_pend_next;
            m_valid_reg  <= m_valid_next;
        end
        cur_reg        <= cur_next;
        mov_key_reg    <= mov_key_next;
        mov_tag_reg    <= mov_tag_next;
        peek_reg       <= peek_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_tag_reg    <= res_tag_next;
        res_count_reg  <= res_count_next;
        m_status_reg   <= m_status_next;
        m_key_reg      <= m_key_next;
        m_tag_reg      <= m_tag_next;
        m_count_reg    <= m_count_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_key_st = m_key_reg;
    assign m_tag_st = m_tag_reg;
    assign m_count  = m_count_reg;

endmodule

@@ verif/tb_binary_min_heap_priority_queue_unit.sv @@
// ----------------------------------------------------------------------------
// tb_binary_min_heap_priority_queue_unit
// Self-checking bench for the min-heap priority queue unit. A clocked driver
// sends queued requests and updates a local heap model on each accepted
// request. A clocked monitor compares every result against the oldest
// predicted one. Stimulus: a directed pass over empty, equal-key, extreme-key
// and unused-command cases, then random traffic under changing back-pressure,
// then a drain of the heap past empty.
// ----------------------------------------------------------------------------
module tb_binary_min_heap_priority_queue_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bmhpq_pkg::*;

    localparam int unsigned HEAP_DEPTH    = CAPACITY_DEF;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned STALL_LIMIT   = 3000;
    localparam int unsigned DRAIN_CYCLES  = 20;
    localparam int unsigned MAX_REPORTS   = 40;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic signed [PORT_KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;
    localparam logic signed [PORT_KEY_W-1:0] KEY_MIN = 32'h8000_0000;

    typedef struct {
        logic [CMD_W-1:0]             command;
        logic signed [PORT_KEY_W-1:0] key;
        logic [PORT_TAG_W-1:0]        tag;
    } heap_request_t;

    typedef struct {
        status_t                      status;
        logic signed [PORT_KEY_W-1:0] key;
        logic [PORT_TAG_W-1:0]        tag;
        logic [OCC_W-1:0]             occupancy;
    } heap_result_t;

    logic                         aclk      = 1'b0;
    logic                         aresetn   = 1'b0;
    logic                         s_valid   = 1'b0;
    logic                         s_ready;
    logic [CMD_W-1:0]             s_command = CMD_INSERT;
    logic signed [PORT_KEY_W-1:0] s_key     = '0;
    logic [PORT_TAG_W-1:0]        s_tag     = '0;
    logic                         m_valid;
    logic                         m_ready   = 1'b0;
    logic [STATUS_W-1:0]          m_status;
    logic signed [PORT_KEY_W-1:0] m_out_key;
    logic [PORT_TAG_W-1:0]        m_out_tag;
    logic [OCC_W-1:0]             m_occupancy;

    // Local heap model
    logic signed [PORT_KEY_W-1:0] model_key [1:HEAP_DEPTH];
    logic [PORT_TAG_W-1:0]        model_tag [1:HEAP_DEPTH];
    int unsigned                  model_count = 0;

    heap_request_t request_queue[$];
    heap_result_t  pending_results[$];
    heap_request_t next_req;
    heap_request_t taken_req;
    heap_result_t  want;

    int          send_idle_pct = 19;
    int          recv_idle_pct = 57;
    logic        hold_start    = 1'b0;
    int unsigned hold_left     = 0;
    int unsigned idle_cycles   = 0;
    int unsigned error_count   = 0;

    binary_min_heap_priority_queue_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_key       (s_key),
        .s_tag       (s_tag),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_out_key   (m_out_key),
        .m_out_tag   (m_out_tag),
        .m_occupancy (m_occupancy)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Exchange two model entries
    function automatic void swap_model(int unsigned a, int unsigned b);
        logic signed [PORT_KEY_W-1:0] k;
        logic [PORT_TAG_W-1:0]        t;
        k = model_key[a];
        t = model_tag[a];
        model_key[a] = model_key[b];
        model_tag[a] = model_tag[b];
        model_key[b] = k;
        model_tag[b] = t;
    endfunction

    // Apply one request to the model and return the result it produces
    function automatic heap_result_t predict_heap_result(heap_request_t req);
        heap_result_t res;
        int unsigned  cur;
        int unsigned  pick;
        bit           done;
        res.status = STATUS_OK;
        res.key    = '0;
        res.tag    = '0;
        case (req.command)
            CMD_INSERT: begin
                if (model_count >= HEAP_DEPTH) begin
                    res.status = STATUS_FULL;
                end else begin
                    model_count++;
                    model_key[model_count] = req.key;
                    model_tag[model_count] = req.tag;
                    // sift up, passing parents with an equal key
                    cur = model_count;
                    while (cur > 1 && !(model_key[cur/2] < model_key[cur])) begin
                        swap_model(cur / 2, cur);
                        cur = cur / 2;
                    end
                end
            end
            CMD_REMOVE, CMD_PEEK: begin
                if (model_count == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    res.key = model_key[1];
                    res.tag = model_tag[1];
                    if (req.command == CMD_REMOVE) begin
                        swap_model(1, model_count);
                        model_count--;
                        // sift down: right child only if strictly smaller,
                        // stop only on a strictly smaller parent
                        cur  = 1;
                        done = 1'b0;
                        while (!done && cur <= model_count / 2) begin
                            pick = 2 * cur;
                            if (pick + 1 <= model_count &&
                                model_key[pick+1] < model_key[pick]) begin
                                pick = pick + 1;
                            end
                            if (model_key[cur] < model_key[pick]) begin
                                done = 1'b1;
                            end else begin
                                swap_model(pick, cur);
                                cur = pick;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        res.occupancy = model_count[OCC_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
        if (error_count < MAX_REPORTS) begin
            $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, exp_val);
        end
        error_count++;
    endtask

    task automatic push_request(logic [CMD_W-1:0] command,
                                logic signed [PORT_KEY_W-1:0] key,
                                logic [PORT_TAG_W-1:0] tag);
        heap_request_t req;
        req.command = command;
        req.key     = key;
        req.tag     = tag;
        request_queue.push_back(req);
    endtask

    // Random request mix biased toward inserts, with keys often tied
    task automatic push_random(int unsigned n);
        int unsigned pick;
        logic [CMD_W-1:0] command;
        logic signed [PORT_KEY_W-1:0] key;
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 50)      command = CMD_INSERT;
            else if (pick < 80) command = CMD_REMOVE;
            else if (pick < 95) command = CMD_PEEK;
            else                command = CMD_UNUSED;
            if ($urandom_range(1) == 1) key = $urandom;
            else                        key = int'($urandom_range(15)) - 8;
            push_request(command, key, 16'($urandom_range(16'hFFFF)));
        end
    endtask

    // Hold the sender until every request is answered
    task automatic wait_drained();
        while (request_queue.size() != 0 || s_valid || pending_results.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // Driver: offer queued requests, update the model on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                taken_req.command = s_command;
                taken_req.key     = s_key;
                taken_req.tag     = s_tag;
                pending_results.push_back(predict_heap_result(taken_req));
            end
            if (!s_valid || s_ready) begin
                if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_req = request_queue.pop_front();
                    s_valid   <= 1'b1;
                    s_command <= next_req.command;
                    s_key     <= next_req.key;
                    s_tag     <= next_req.tag;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off
    always @(posedge aclk) begin
        if (hold_start) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: compare each result with the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result status", 32'(m_status), 0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_status !== want.status)
                        report_mismatch("status", 32'(m_status), 32'(want.status));
                    if (m_out_key !== want.key)
                        report_mismatch("out_key", m_out_key, want.key);
                    if (m_out_tag !== want.tag)
                        report_mismatch("out_tag", 32'(m_out_tag), 32'(want.tag));
                    if (m_occupancy !== want.occupancy)
                        report_mismatch("occupancy", 32'(m_occupancy),
                                        32'(want.occupancy));
                end
            end
            m_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb_binary_min_heap_priority_queue_unit: errors");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty heap, extreme keys, equal keys, unused command
        push_request(CMD_PEEK, 0, 0);
        push_request(CMD_REMOVE, 0, 0);
        push_request(CMD_UNUSED, KEY_MIN, 16'hFFFF);
        push_request(CMD_INSERT, KEY_MAX, 16'hFFFF);
        push_request(CMD_INSERT, KEY_MIN, 16'h0000);
        push_request(CMD_INSERT, 0, 16'h0001);
        push_request(CMD_INSERT, -1, 16'h0002);
        push_request(CMD_INSERT, 5, 16'h000A);
        push_request(CMD_INSERT, 5, 16'h000B);
        push_request(CMD_INSERT, 5, 16'h000C);
        push_request(CMD_INSERT, 5, 16'h000D);
        push_request(CMD_PEEK, 0, 0);
        push_request(CMD_UNUSED, KEY_MAX, 16'h0000);
        repeat (8) push_request(CMD_REMOVE, 0, 0);
        push_request(CMD_REMOVE, 0, 0);
        push_request(CMD_PEEK, 0, 0);
        wait_drained();

        // Random, slow receiver, with a long hold-off to back up the input
        push_random(190);
        hold_start = 1'b1;
        @(negedge aclk);
        hold_start = 1'b0;
        wait_drained();

        // Random, slow sender
        send_idle_pct = 57;
        recv_idle_pct = 19;
        push_random(190);
        wait_drained();

        // Random, no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_random(190);
        wait_drained();

        // Drain past empty
        push_request(CMD_PEEK, 0, 0);
        push_request(CMD_UNUSED, 0, 0);
        repeat (model_count + 2) push_request(CMD_REMOVE, 0, 0);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            report_mismatch("results still owed", pending_results.size(), 0);
        end
        if (error_count == 0) begin
            $display("tb_binary_min_heap_priority_queue_unit: clean");
        end else begin
            $display("tb_binary_min_heap_priority_queue_unit: errors");
        end
        $finish;
    end

endmodule
